>>> design/lv3_pkg.sv
// Shared types and constants for the 3x3 local variance filter.
package lv3_pkg;

	// Input op codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 11;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// Queue depths
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int RES_W     = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic       op;
		logic [7:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic [20:0] variance_x81;
		logic [11:0] window_sum;
		logic        row_end;
		logic        frame_end;
	} out_item_t;

	// One classified step for the datapath
	typedef struct packed {
		logic       write;
		logic [7:0] pixel;
		logic       emit;
		logic       at_left;
		logic       at_right;
		logic       at_top;
		logic       at_bottom;
	} cmd_t;

endpackage

>>> design/local_variance_3x3_filter_top.sv
// Top level of the streaming 3x3 local variance filter.
//
// Input channel (in_valid, in_stall, in_data): one 8-bit pixel per request in
// raster order, or a flush request that drains the results still pending once
// the last pixel of a frame has gone in. Output channel (out_valid, out_stall,
// out_data): for every pixel, 81 times its 3x3 variance and the window sum,
// with row and frame end marks. Results lag their pixel by one row plus one
// pixel of requests; width + 1 flush requests finish a frame.
// Throughput is one request per cycle while the request queue has room and the
// back end holds a free output slot. A result passes the request queue, the line
// store read, the window register, three arithmetic stages and the output queue.
// The configuration port sets frame width and height; a write restarts the
// frame. At reset the sizes return to 640 by 480, the window clears to zero and
// all positions return to zero; the line stores are not cleared.
// When the receiver stalls, results collect in an eight-entry output queue and
// a four-entry request queue, after which in_stall rises.
module local_variance_3x3_filter_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  lv3_pkg::in_item_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output lv3_pkg::out_item_t                   out_data,
	input  logic                                 cfg_write,
	input  logic [lv3_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [lv3_pkg::CFG_DATA_W-1:0]       cfg_data
);

	import lv3_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int SW_W  = $clog2(MAX_WIDTH + 1);
	localparam int SH_W  = $clog2(MAX_HEIGHT + 1);
	localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
	localparam int Q_W   = COL_W + $bits(cmd_t);

	logic [SW_W-1:0] width_q;
	logic [SH_W-1:0] height_q;

	logic             take;
	logic             cmd_push;
	cmd_t             front_cmd;
	logic [COL_W-1:0] front_col;
	cmd_t             back_cmd;
	logic [COL_W-1:0] back_col;
	logic [Q_W-1:0]   q_pop_data;
	logic             cmd_pop;
	logic             cmd_full;
	logic             cmd_empty;

	// Sizes are held already clamped to 1..maximum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW_W'(RST_W);
			height_q <= SH_W'(RST_H);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					if (cfg_data == '0) begin
						width_q <= SW_W'(1);
					end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
						width_q <= SW_W'(MAX_WIDTH);
					end else begin
						width_q <= SW_W'(cfg_data);
					end
				end
				REG_FRAME_HEIGHT: begin
					if (cfg_data == '0) begin
						height_q <= SH_W'(1);
					end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
						height_q <= SH_W'(MAX_HEIGHT);
					end else begin
						height_q <= SH_W'(cfg_data);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign in_stall = cmd_full;
	assign take     = in_valid && !cmd_full;

	lv3_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_data (in_data),
		.restart (cfg_write),
		.width   (width_q),
		.height  (height_q),
		.step    (cmd_push),
		.cmd     (front_cmd),
		.cmd_col (front_col)
	);

	lv3_fifo #(
		.WIDTH (Q_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data ({front_col, front_cmd}),
		.pop       (cmd_pop),
		.pop_data  (q_pop_data),
		.full      (cmd_full),
		.empty     (cmd_empty)
	);

	assign {back_col, back_cmd} = q_pop_data;

	lv3_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (back_cmd),
		.cmd_col   (back_col),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("request queue popped while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("request queue pushed while full");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.frame_end || out_data.row_end))
		else $error("frame end without row end");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.variance_x81 <= 21'd1300500 &&
			out_data.window_sum <= 12'd2295))
		else $error("result out of range");

endmodule

>>> design/lv3_fifo.sv
// Small register-based first-in first-out queue.
module lv3_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/lv3_front.sv
// Front end: tracks input and output raster positions and classifies each request.
module lv3_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  lv3_pkg::in_item_t                 in_data,
	input  logic                              restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
	output logic                              step,
	output lv3_pkg::cmd_t                     cmd,
	output logic [$clog2(MAX_WIDTH)-1:0]      cmd_col
);

	import lv3_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int SW_W   = $clog2(MAX_WIDTH + 1);
	localparam int SH_W   = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
	localparam int OROW_W = $clog2(MAX_HEIGHT);

	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [OROW_W-1:0] out_row_q;

	logic draining;
	logic last_col;
	logic emit;
	logic at_right;
	logic at_bottom;

	// Once the last row has gone in, the remaining requests only drain the window.
	assign draining  = (in_row_q >= ROW_W'(height));
	assign step      = take && !(!draining && (in_data.op == OP_FLUSH));
	assign last_col  = (SW_W'(in_col_q) == width - SW_W'(1));
	assign emit      = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
	assign at_right  = (SW_W'(out_col_q) == width - SW_W'(1));
	assign at_bottom = (SH_W'(out_row_q) == height - SH_W'(1));

	always_comb begin
		cmd.write     = !draining;
		cmd.pixel     = in_data.pixel;
		cmd.emit      = emit;
		cmd.at_left   = (out_col_q == '0);
		cmd.at_right  = at_right;
		cmd.at_top    = (out_row_q == '0);
		cmd.at_bottom = at_bottom;
	end

	assign cmd_col = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart || (step && emit && at_right && at_bottom)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (step) begin
			if (last_col) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + 1'b1;
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
			if (emit) begin
				if (at_right) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> design/lv3_back.sv
// Back end: line stores, 3x3 window and the variance arithmetic pipeline.
module lv3_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  lv3_pkg::cmd_t                 cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0]  cmd_col,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lv3_pkg::out_item_t            out_data
);

	import lv3_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	function automatic logic [3:0] tap(input logic [1:0] c, input logic [1:0] r);
		return 4'(c) * 4'd3 + 4'(r);
	endfunction

	logic [7:0] line_a [MAX_WIDTH];
	logic [7:0] line_b [MAX_WIDTH];

	logic [RES_W-1:0] reserved_q;
	logic             out_take;
	logic             out_empty;

	// Stage 1: line store read data
	logic             v_s1;
	cmd_t             cmd_s1;
	logic [COL_W-1:0] col_s1;
	logic [7:0]       rd_a_s1;
	logic [7:0]       rd_b_s1;
	logic             byp_s1;
	logic [7:0]       byp_px_s1;
	logic [7:0]       mid_s1;
	logic [7:0]       up_s1;
	logic [7:0]       low_s1;

	logic [7:0] window_q [9];

	// Stage 2: window ready
	logic v_s2;
	cmd_t cmd_s2;
	logic [15:0] sq_c [9];

	// Stage 3: pixels and their squares
	logic        v_s3;
	cmd_t        cmd_s3;
	logic [7:0]  px_s3 [9];
	logic [15:0] sq_s3 [9];
	logic [11:0] sum_c;
	logic [19:0] sumsq_c;

	// Stage 4: window sums
	logic        v_s4;
	cmd_t        cmd_s4;
	logic [11:0] sum_s4;
	logic [19:0] sumsq_s4;

	// Stage 5: products
	logic        v_s5;
	cmd_t        cmd_s5;
	logic [11:0] sum_s5;
	logic [22:0] nine_sq_s5;
	logic [22:0] sum_sq_s5;

	out_item_t res;

	// Each request that yields a result holds an output slot from issue to delivery.
	assign cmd_pop  = cmd_valid && (reserved_q < RES_W'(OUT_DEPTH));
	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else begin
			reserved_q <= reserved_q + RES_W'(cmd_pop && cmd.emit) - RES_W'(out_take);
		end
	end

	// Line store A is read before the new pixel overwrites it; B takes A's old value.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			rd_a_s1 <= line_a[cmd_col];
			rd_b_s1 <= line_b[cmd_col];
			if (cmd.write) begin
				line_a[cmd_col] <= cmd.pixel;
			end
		end
		if (v_s1 && cmd_s1.write) begin
			line_b[col_s1] <= mid_s1;
		end
	end

	// A one-pixel-wide frame reads store B at the column still being written.
	assign mid_s1 = rd_a_s1;
	assign up_s1  = byp_s1 ? byp_px_s1 : rd_b_s1;
	assign low_s1 = cmd_s1.write ? cmd_s1.pixel : mid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			byp_s1 <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				window_q[k] <= '0;
			end
		end else begin
			v_s1   <= cmd_pop;
			byp_s1 <= cmd_pop && v_s1 && cmd_s1.write && (col_s1 == cmd_col);
			v_s2   <= v_s1 && cmd_s1.emit;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			if (v_s1) begin
				for (int k = 0; k < 6; k++) begin
					window_q[k] <= window_q[k+3];
				end
				window_q[6] <= up_s1;
				window_q[7] <= mid_s1;
				window_q[8] <= low_s1;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			sq_c[k] = 16'(window_q[k]) * 16'(window_q[k]);
		end
	end

	// Edge replication picks the centre column or row in place of one past the border.
	always_comb begin
		logic [1:0] csel [3];
		logic [1:0] rsel [3];
		logic [3:0] idx;
		csel[0] = cmd_s3.at_left   ? 2'd1 : 2'd0;
		csel[1] = 2'd1;
		csel[2] = cmd_s3.at_right  ? 2'd1 : 2'd2;
		rsel[0] = cmd_s3.at_top    ? 2'd1 : 2'd0;
		rsel[1] = 2'd1;
		rsel[2] = cmd_s3.at_bottom ? 2'd1 : 2'd2;
		sum_c   = '0;
		sumsq_c = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				idx     = tap(csel[i], rsel[j]);
				sum_c   = sum_c + 12'(px_s3[idx]);
				sumsq_c = sumsq_c + 20'(sq_s3[idx]);
			end
		end
	end

	always_ff @(posedge clk) begin
		col_s1    <= cmd_col;
		cmd_s1    <= cmd;
		byp_px_s1 <= mid_s1;
		cmd_s2    <= cmd_s1;
		cmd_s3    <= cmd_s2;
		for (int k = 0; k < 9; k++) begin
			px_s3[k] <= window_q[k];
			sq_s3[k] <= sq_c[k];
		end
		cmd_s4     <= cmd_s3;
		sum_s4     <= sum_c;
		sumsq_s4   <= sumsq_c;
		cmd_s5     <= cmd_s4;
		sum_s5     <= sum_s4;
		nine_sq_s5 <= {sumsq_s4, 3'b000} + 23'(sumsq_s4);
		sum_sq_s5  <= 23'(sum_s4) * 23'(sum_s4);
	end

	always_comb begin
		logic [22:0] diff;
		diff             = nine_sq_s5 - sum_sq_s5;
		res.variance_x81 = diff[20:0];
		res.window_sum   = sum_s5;
		res.row_end      = cmd_s5.at_right;
		res.frame_end    = cmd_s5.at_right && cmd_s5.at_bottom;
	end

	lv3_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s5),
		.push_data (res),
		.pop       (out_take),
		.pop_data  (out_data),
		.full      (),
		.empty     (out_empty)
	);

	assign out_valid = !out_empty;

endmodule
